### sv/tsts_pkg.sv
// Package: shared types and constants for the time-slice task scheduler.
package tsts_pkg;

	localparam int MaxTasks = 16;
	localparam int SlotW = $clog2(MaxTasks);
	localparam int CurW = $clog2(MaxTasks + 1);

	localparam logic CfgPreempt = 1'b0;
	localparam logic CfgSlice = 1'b1;

	localparam logic [2:0] KindTick = 3'd0;
	localparam logic [2:0] KindCreate = 3'd1;
	localparam logic [2:0] KindEnd = 3'd2;
	localparam logic [2:0] KindSleep = 3'd3;
	localparam logic [2:0] KindYield = 3'd4;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusFull = 2'd1;
	localparam logic [1:0] StatusNoCur = 2'd2;

	localparam logic [1:0] ModeReady = 2'd0;
	localparam logic [1:0] ModeRunning = 2'd1;
	localparam logic [1:0] ModeSleeping = 2'd2;

	localparam logic [15:0] SliceReset = 16'd100;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPLY,
		ST_WAKE,
		ST_CUR,
		ST_SCAN1,
		ST_REFILL,
		ST_SCAN2,
		ST_SELECT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic wake;
		logic check_cur;
		logic scan_clear;
		logic scan_step;
		logic refill;
		logic select;
	} cmd_t;

	typedef struct packed {
		logic pass_on;
		logic cur_charged;
		logic scan_done;
		logic found;
		logic stop;
	} stat_t;

endpackage

### sv/tsts_ctrl.sv
// Controller: sequences one transaction through apply, wake, charge, scan, refill and select steps.
module tsts_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  tsts_pkg::stat_t stat,
	output tsts_pkg::cmd_t cmd
);

	tsts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			tsts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = tsts_pkg::ST_APPLY;
				end
			end
			tsts_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d = stat.stop ? tsts_pkg::ST_OUT : tsts_pkg::ST_WAKE;
			end
			tsts_pkg::ST_WAKE: begin
				if (stat.pass_on) begin
					cmd.wake = 1'b1;
					state_d = tsts_pkg::ST_CUR;
				end else begin
					state_d = tsts_pkg::ST_OUT;
				end
			end
			tsts_pkg::ST_CUR: begin
				cmd.check_cur = 1'b1;
				cmd.scan_clear = 1'b1;
				state_d = stat.cur_charged ? tsts_pkg::ST_OUT : tsts_pkg::ST_SCAN1;
			end
			tsts_pkg::ST_SCAN1: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = stat.found ? tsts_pkg::ST_SELECT : tsts_pkg::ST_REFILL;
				end
			end
			tsts_pkg::ST_REFILL: begin
				cmd.refill = 1'b1;
				cmd.scan_clear = 1'b1;
				state_d = tsts_pkg::ST_SCAN2;
			end
			tsts_pkg::ST_SCAN2: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = tsts_pkg::ST_SELECT;
				end
			end
			tsts_pkg::ST_SELECT: begin
				cmd.select = 1'b1;
				state_d = tsts_pkg::ST_OUT;
			end
			tsts_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = tsts_pkg::ST_IDLE;
				end
			end
			default: state_d = tsts_pkg::ST_IDLE;
		endcase
	end

endmodule

### sv/tsts_dp.sv
// Datapath: task table, current slot, oldest-task scan and result registers.
module tsts_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic [2:0] kind,
	input  logic [31:0] sleep_ticks,
	input  tsts_pkg::cmd_t cmd,
	output tsts_pkg::stat_t stat,
	output logic [1:0] status,
	output logic [31:0] created_pid,
	output logic [3:0] running_slot,
	output logic [31:0] running_pid,
	output logic idle,
	output logic switched
);

	localparam int N = tsts_pkg::MaxTasks;
	localparam int SW = tsts_pkg::SlotW;
	localparam int CW = tsts_pkg::CurW;
	localparam logic [CW-1:0] NoneSlot = CW'(N);

	logic preempt_q;
	logic [15:0] slice_q;
	logic [N-1:0] valid_q;
	logic [1:0] mode_q [N];
	logic [15:0] left_q [N];
	logic [31:0] total_q [N];
	logic [31:0] tmo_q [N];
	logic [31:0] ident_q [N];
	logic [CW-1:0] cur_q;
	logic [31:0] next_q;
	logic [CW-1:0] live_q;
	logic [2:0] kind_q;
	logic [31:0] ticks_q;
	logic [1:0] status_q;
	logic [31:0] created_q;
	logic sw_q;
	logic [CW-1:0] idx_q;
	logic found_q;
	logic [SW-1:0] best_q;
	logic [31:0] age_q;

	logic cur_ok;
	logic [SW-1:0] cur_i;
	logic [SW-1:0] idx_i;
	logic [SW-1:0] free_i;
	logic free_found;
	logic [31:0] age;
	logic elig;
	logic call_kind;

	assign cur_ok = cur_q < NoneSlot;
	assign cur_i = cur_q[SW-1:0];
	assign idx_i = idx_q[SW-1:0];
	assign age = next_q - ident_q[idx_i];
	assign elig = valid_q[idx_i] && mode_q[idx_i] == tsts_pkg::ModeReady
		&& left_q[idx_i] != 16'd0;
	assign call_kind = kind_q == tsts_pkg::KindEnd || kind_q == tsts_pkg::KindSleep
		|| kind_q == tsts_pkg::KindYield;

	always_comb begin
		free_i = '0;
		free_found = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_i = SW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign stat.pass_on = preempt_q && live_q != '0;
	assign stat.cur_charged = cur_ok && left_q[cur_i] != 16'd0;
	assign stat.scan_done = idx_q == CW'(N - 1);
	assign stat.found = found_q || elig;
	assign stat.stop = !(kind_q == tsts_pkg::KindTick || (call_kind && cur_ok));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preempt_q <= 1'b0;
			slice_q <= tsts_pkg::SliceReset;
			valid_q <= '0;
			cur_q <= NoneSlot;
			next_q <= '0;
			live_q <= '0;
			for (int i = 0; i < N; i++) begin
				mode_q[i] <= tsts_pkg::ModeReady;
				left_q[i] <= '0;
				total_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tsts_pkg::CfgPreempt: preempt_q <= cfg_wdata[0];
					tsts_pkg::CfgSlice: slice_q <= cfg_wdata;
				endcase
			end
			if (cmd.apply) begin
				if (kind_q == tsts_pkg::KindCreate) begin
					if (free_found) begin
						valid_q[free_i] <= 1'b1;
						mode_q[free_i] <= tsts_pkg::ModeReady;
						left_q[free_i] <= slice_q;
						total_q[free_i] <= '0;
						next_q <= next_q + 32'd1;
						live_q <= live_q + CW'(1);
					end
				end else if (cur_ok) begin
					case (kind_q)
						tsts_pkg::KindEnd: begin
							valid_q[cur_i] <= 1'b0;
							mode_q[cur_i] <= tsts_pkg::ModeReady;
							left_q[cur_i] <= '0;
							if (live_q != '0) live_q <= live_q - CW'(1);
							cur_q <= NoneSlot;
						end
						tsts_pkg::KindSleep: begin
							mode_q[cur_i] <= tsts_pkg::ModeSleeping;
							left_q[cur_i] <= '0;
						end
						tsts_pkg::KindYield: left_q[cur_i] <= '0;
						default: ;
					endcase
				end
			end
			if (cmd.wake) begin
				for (int i = 0; i < N; i++) begin
					if (valid_q[i] && mode_q[i] == tsts_pkg::ModeSleeping
						&& tmo_q[i] == 32'd1) begin
						mode_q[i] <= tsts_pkg::ModeReady;
					end
				end
			end
			if (cmd.check_cur && cur_ok) begin
				if (left_q[cur_i] != 16'd0) begin
					left_q[cur_i] <= left_q[cur_i] - 16'd1;
					total_q[cur_i] <= total_q[cur_i] + 32'd1;
				end else if (mode_q[cur_i] == tsts_pkg::ModeRunning) begin
					mode_q[cur_i] <= tsts_pkg::ModeReady;
				end
			end
			if (cmd.refill) begin
				for (int i = 0; i < N; i++) begin
					if (valid_q[i]) left_q[i] <= slice_q;
				end
			end
			if (cmd.select) begin
				if (found_q) begin
					mode_q[best_q] <= tsts_pkg::ModeRunning;
					left_q[best_q] <= left_q[best_q] - 16'd1;
					total_q[best_q] <= total_q[best_q] + 32'd1;
					cur_q <= CW'(best_q);
				end else begin
					cur_q <= NoneSlot;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			ticks_q <= sleep_ticks;
			sw_q <= 1'b0;
		end
		if (cmd.apply) begin
			status_q <= tsts_pkg::StatusOk;
			created_q <= '0;
			if (kind_q == tsts_pkg::KindCreate) begin
				if (free_found) begin
					tmo_q[free_i] <= '0;
					ident_q[free_i] <= next_q;
					created_q <= next_q;
				end else begin
					status_q <= tsts_pkg::StatusFull;
				end
			end else if (call_kind) begin
				if (cur_ok) begin
					if (kind_q == tsts_pkg::KindSleep) tmo_q[cur_i] <= ticks_q;
				end else begin
					status_q <= tsts_pkg::StatusNoCur;
				end
			end
		end
		if (cmd.wake) begin
			for (int i = 0; i < N; i++) begin
				if (valid_q[i] && mode_q[i] == tsts_pkg::ModeSleeping) begin
					tmo_q[i] <= tmo_q[i] - 32'd1;
				end
			end
		end
		if (cmd.scan_clear) begin
			idx_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + CW'(1);
			if (elig && (!found_q || age > age_q)) begin
				found_q <= 1'b1;
				best_q <= idx_i;
				age_q <= age;
			end
		end
		if (cmd.select) sw_q <= found_q;
	end

	assign status = status_q;
	assign created_pid = created_q;
	assign idle = !cur_ok;
	assign running_slot = cur_ok ? 4'(cur_i) : 4'd0;
	assign running_pid = cur_ok ? ident_q[cur_i] : 32'd0;
	assign switched = sw_q;

endmodule

### sv/time_slice_task_scheduler.sv
// Top level: round-robin time-slice task scheduler over a sixteen-slot task table.
// One transaction at a time. A create, an unknown kind or a call with no current task
// goes from the apply step straight to the result; a pass with preemption off or no
// live tasks stops at the wake step; a tick that charges the current task stops after
// the charge; a pass that must search scans one slot per cycle through the shared age
// compare, and when every slice has to be refilled the table is scanned again. The
// result holds until taken, then the next is accepted.
module time_slice_task_scheduler (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] kind,
	input  logic [31:0] sleep_ticks,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [31:0] created_pid,
	output logic [3:0] running_slot,
	output logic [31:0] running_pid,
	output logic idle,
	output logic switched
);

	tsts_pkg::cmd_t cmd;
	tsts_pkg::stat_t stat;

	tsts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	tsts_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .kind(kind), .sleep_ticks(sleep_ticks), .cmd(cmd),
		.stat(stat), .status(status), .created_pid(created_pid),
		.running_slot(running_slot), .running_pid(running_pid), .idle(idle),
		.switched(switched)
	);

endmodule
